### src/tiled_blit_address_generator_assert.svh
// Assertion macros for the tiled blit address generator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TILED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH
`define TILED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define TBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tba_pkg.sv
// Shared types, constants and the in-tile unswizzle for the tiled blit
// address generator. No dependencies.
package tba_pkg;

  localparam int COORD_W     = 13;             // pixel coordinate width
  localparam int ADDR_W      = 26;             // word address width
  localparam int STRIDE_W    = 14;             // row pitch register width
  localparam int TILE_SHIFT  = 5;              // 32 pixels per tile side
  localparam int TILE_W      = COORD_W - 4;    // tile count, holds 2^(COORD_W-5)
  localparam int IDX_W       = COORD_W - 5;    // tile index
  localparam int WORD_W      = 10;             // word within a 1024-word tile
  localparam int ROWY_W      = COORD_W + 1;    // origin_y + 32*tile_row
  localparam int PIX_W       = 5;              // xx / yy inside a tile
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 26;
  localparam int IN_TDATA_W  = 56;             // 4 x 13 bits, padded to bytes
  localparam int OUT_TDATA_W = 56;             // 2 x 26 bits, padded to bytes

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIDE   = 2'd0,
    CFG_SRC_BASE = 2'd1,
    CFG_DST_BASE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // One word position handed from the stepper to the address pipe
  typedef struct packed {
    logic                valid;
    logic [ROWY_W-1:0]   row_y;
    logic [COORD_W-1:0]  origin_x;
    logic [IDX_W-1:0]    col;
    logic [WORD_W-1:0]   word;
    logic                last;
  } step_item_t;

  // Stepper status, watched by the top-level checks
  typedef struct packed {
    logic busy;
    logic launch;
    logic launch_last;
  } step_stat_t;

  typedef struct packed {
    logic [PIX_W-1:0] xx;
    logic [PIX_W-1:0] yy;
  } pix_t;

  // Undo the in-tile XOR swizzle: bit 8 of the index flips bit 5.
  function automatic pix_t unswizzle(input logic [WORD_W-1:0] i);
    logic [WORD_W-1:0] j;
    pix_t              p;
    j    = i;
    j[5] = i[5] ^ i[8];
    p.xx = {j[5:3], j[1:0]};
    p.yy = {j[9:6], j[2]};
    return p;
  endfunction

endpackage

### src/tba_stepper.sv
// Box walker: loads a box on start, steps row/tile/word counters on each
// step transfer while a box is active and hands one word position per
// step to the address pipe. Depends on tba_pkg.
module tba_stepper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           func,
  input  logic [tba_pkg::COORD_W-1:0]    box_x1,
  input  logic [tba_pkg::COORD_W-1:0]    box_y1,
  input  logic [tba_pkg::COORD_W-1:0]    box_x2,
  input  logic [tba_pkg::COORD_W-1:0]    box_y2,
  input  logic                           s2_ready,
  output tba_pkg::step_item_t            item,
  output tba_pkg::step_stat_t            stat
);

  logic                          busy_r, busy_nxt;
  logic [tba_pkg::COORD_W-1:0]   origin_x_r, origin_x_nxt;
  logic [tba_pkg::COORD_W-1:0]   origin_y_r, origin_y_nxt;
  logic [tba_pkg::TILE_W-1:0]    across_r, across_nxt;
  logic [tba_pkg::TILE_W-1:0]    down_r, down_nxt;
  logic [tba_pkg::IDX_W-1:0]     row_r, row_nxt;
  logic [tba_pkg::IDX_W-1:0]     col_r, col_nxt;
  logic [tba_pkg::WORD_W-1:0]    word_r, word_nxt;
  tba_pkg::step_item_t           item_r, item_nxt;

  logic                          accept;
  logic                          is_start;
  logic                          launch;
  logic                          empty_box;
  logic [tba_pkg::COORD_W-1:0]   org_x, org_y;
  logic [tba_pkg::COORD_W-1:0]   ext_x, ext_y;
  logic [tba_pkg::COORD_W:0]     round_x, round_y;
  logic                          word_end, col_end, row_end;

  // Stage register is free when empty or moving on this cycle
  assign in_tready = !item_r.valid || s2_ready;
  assign accept    = in_tvalid && in_tready;
  assign is_start  = (tba_pkg::func_t'(func) == tba_pkg::FUNC_START);
  assign launch    = accept && !is_start && busy_r;

  // Box setup: origin rounded down to a tile, extents rounded up
  assign empty_box = (box_x2 <= box_x1) || (box_y2 <= box_y1);
  assign org_x     = {box_x1[tba_pkg::COORD_W-1:tba_pkg::TILE_SHIFT],
                      tba_pkg::TILE_SHIFT'(0)};
  assign org_y     = {box_y1[tba_pkg::COORD_W-1:tba_pkg::TILE_SHIFT],
                      tba_pkg::TILE_SHIFT'(0)};
  assign ext_x     = box_x2 - org_x;
  assign ext_y     = box_y2 - org_y;
  assign round_x   = {1'b0, ext_x} + (tba_pkg::COORD_W+1)'(31);
  assign round_y   = {1'b0, ext_y} + (tba_pkg::COORD_W+1)'(31);

  // Wrap points of the three counters
  assign word_end = (word_r == {tba_pkg::WORD_W{1'b1}});
  assign col_end  = (({1'b0, col_r} + tba_pkg::TILE_W'(1)) >= across_r);
  assign row_end  = (({1'b0, row_r} + tba_pkg::TILE_W'(1)) >= down_r);

  // Counter and box state next values
  always_comb begin
    busy_nxt     = busy_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    across_nxt   = across_r;
    down_nxt     = down_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    word_nxt     = word_r;
    if (accept && is_start) begin
      row_nxt  = '0;
      col_nxt  = '0;
      word_nxt = '0;
      if (empty_box) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt     = 1'b1;
        origin_x_nxt = org_x;
        origin_y_nxt = org_y;
        across_nxt   = round_x[tba_pkg::COORD_W:tba_pkg::TILE_SHIFT];
        down_nxt     = round_y[tba_pkg::COORD_W:tba_pkg::TILE_SHIFT];
      end
    end else if (launch) begin
      if (!word_end) begin
        word_nxt = word_r + tba_pkg::WORD_W'(1);
      end else begin
        word_nxt = '0;
        if (!col_end) begin
          col_nxt = col_r + tba_pkg::IDX_W'(1);
        end else begin
          col_nxt = '0;
          if (!row_end) begin
            row_nxt = row_r + tba_pkg::IDX_W'(1);
          end else begin
            row_nxt  = '0;
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Stage register toward the address pipe
  always_comb begin
    item_nxt = item_r;
    if (in_tready) begin
      item_nxt.valid    = launch;
      item_nxt.row_y    = tba_pkg::ROWY_W'(origin_y_r)
                        + tba_pkg::ROWY_W'({row_r, tba_pkg::TILE_SHIFT'(0)});
      item_nxt.origin_x = origin_x_r;
      item_nxt.col      = col_r;
      item_nxt.word     = word_r;
      item_nxt.last     = word_end && col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      across_r     <= '0;
      down_r       <= '0;
      row_r        <= '0;
      col_r        <= '0;
      word_r       <= '0;
      item_r       <= '0;
    end else begin
      busy_r       <= busy_nxt;
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      across_r     <= across_nxt;
      down_r       <= down_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      word_r       <= word_nxt;
      item_r       <= item_nxt;
    end
  end

  assign item             = item_r;
  assign stat.busy        = busy_r;
  assign stat.launch      = launch;
  assign stat.launch_last = launch && word_end && col_end && row_end;

endmodule

### src/tba_addr_pipe.sv
// Address pipe: multiply stage (row and in-tile row offsets) followed by
// the final add stage, which is also the output register.
// Depends on tba_pkg.
module tba_addr_pipe (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tba_pkg::step_item_t            item,
  output logic                           s2_ready,
  input  logic [tba_pkg::STRIDE_W-1:0]   stride,
  input  logic [tba_pkg::ADDR_W-1:0]     src_base,
  input  logic [tba_pkg::ADDR_W-1:0]     dst_base,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tba_pkg::ADDR_W-1:0]     src_addr,
  output logic [tba_pkg::ADDR_W-1:0]     dst_addr,
  output logic                           out_last
);

  logic                                     v2_r;
  logic [tba_pkg::ADDR_W-1:0]               prow_r, pyy_r, src_part_r, dst_part_r;
  logic                                     last2_r;
  logic                                     v3_r;
  logic [tba_pkg::ADDR_W-1:0]               src_r, dst_r;
  logic                                     last3_r;

  logic                                     s3_ready;
  tba_pkg::pix_t                            pix;
  logic [tba_pkg::ROWY_W+tba_pkg::STRIDE_W-1:0] prod_row;
  logic [tba_pkg::PIX_W+tba_pkg::STRIDE_W-1:0]  prod_yy;

  // Each stage moves when the next one is empty or moving
  assign s3_ready = !v3_r || out_ready;
  assign s2_ready = !v2_r || s3_ready;

  assign pix      = tba_pkg::unswizzle(item.word);
  assign prod_row = item.row_y * stride;
  assign prod_yy  = pix.yy * stride;

  // Stage 2: products plus the additive terms that need no product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      prow_r     <= tba_pkg::ADDR_W'(prod_row);
      pyy_r      <= tba_pkg::ADDR_W'(prod_yy);
      src_part_r <= src_base + tba_pkg::ADDR_W'(item.origin_x)
                  + tba_pkg::ADDR_W'({item.col, tba_pkg::TILE_SHIFT'(0)})
                  + tba_pkg::ADDR_W'(pix.xx);
      dst_part_r <= dst_base
                  + tba_pkg::ADDR_W'({item.origin_x, tba_pkg::TILE_SHIFT'(0)})
                  + tba_pkg::ADDR_W'({item.col, tba_pkg::WORD_W'(0)})
                  + tba_pkg::ADDR_W'(item.word);
      last2_r    <= item.last;
    end
  end

  // Stage 3: final sums into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_ready) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      src_r   <= src_part_r + prow_r + pyy_r;
      dst_r   <= dst_part_r + prow_r;
      last3_r <= last2_r;
    end
  end

  assign out_valid = v3_r;
  assign src_addr  = src_r;
  assign dst_addr  = dst_r;
  assign out_last  = last3_r;

endmodule

### src/tiled_blit_address_generator.sv
// Tiled blit address generator top level: configuration registers, box
// walker and address pipe. Depends on tba_pkg, tba_stepper, tba_addr_pipe
// and the assertion header.
//
// A start transfer (tuser = 0) loads a box; each step transfer (tuser = 1)
// while a box is active yields one source/destination word-address pair,
// walking tile rows, tiles in the row, then the 1024 words of a 32x32 tile;
// tlast marks the final word of the box. Start transfers and steps with no
// active box yield nothing. The block takes one transfer per clock cycle
// while out_tready is high; each result passes the stepper register, the
// multiply stage with the two row-pitch products and the add stage that
// is also the output register. Stages advance independently, so input
// transfers keep flowing while a result waits on out_tready until all
// stages are full. Write configuration only while no results are outstanding.
`include "tiled_blit_address_generator_assert.svh"

module tiled_blit_address_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [tba_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tba_pkg::IN_TDATA_W-1:0]     in_tdata,  // box_x1, box_y1, box_x2, box_y2, pad
  input  logic                               in_tuser,  // func
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tba_pkg::OUT_TDATA_W-1:0]    out_tdata, // src_word_addr, dst_word_addr, pad
  output logic                               out_tlast  // last_of_box
);

  localparam int CW = tba_pkg::COORD_W;
  localparam int AW = tba_pkg::ADDR_W;

  logic [tba_pkg::STRIDE_W-1:0] stride_r;
  logic [AW-1:0]                src_base_r;
  logic [AW-1:0]                dst_base_r;

  tba_pkg::step_item_t          item;
  tba_pkg::step_stat_t          stat;
  logic                         s2_ready;
  logic [AW-1:0]                src_addr, dst_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r   <= tba_pkg::STRIDE_W'(1280);
      src_base_r <= '0;
      dst_base_r <= '0;
    end else if (cfg_wr_en) begin
      case (tba_pkg::cfg_reg_t'(cfg_addr))
        tba_pkg::CFG_STRIDE:   stride_r   <= cfg_wdata[tba_pkg::STRIDE_W-1:0];
        tba_pkg::CFG_SRC_BASE: src_base_r <= cfg_wdata[AW-1:0];
        tba_pkg::CFG_DST_BASE: dst_base_r <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  tba_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tuser),
    .box_x1    (in_tdata[CW-1:0]),
    .box_y1    (in_tdata[2*CW-1:CW]),
    .box_x2    (in_tdata[3*CW-1:2*CW]),
    .box_y2    (in_tdata[4*CW-1:3*CW]),
    .s2_ready  (s2_ready),
    .item      (item),
    .stat      (stat)
  );

  tba_addr_pipe u_addr_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .s2_ready  (s2_ready),
    .stride    (stride_r),
    .src_base  (src_base_r),
    .dst_base  (dst_base_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .out_last  (out_tlast)
  );

  assign out_tdata = {(tba_pkg::OUT_TDATA_W - 2*AW)'(0), dst_addr, src_addr};

  // Checks on the walker
  `TBA_ASSERT_NOW(a_launch_needs_step, stat.launch, in_tvalid && in_tready && in_tuser, "word launched without a step transfer")
  `TBA_ASSERT_NEXT(a_last_ends_box, stat.launch_last, !stat.busy, "box still active after its last word")
  `TBA_ASSERT_NEXT(a_idle_step_noop, in_tvalid && in_tready && in_tuser && !stat.busy, !stat.busy && !item.valid, "step while idle changed state")

endmodule

### tb/testbench.sv
// Self-checking bench for tiled_blit_address_generator: stream driver, result
// monitor and a cycle-free address predictor for the tile walk.
// Depends on tba_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 8;     // covers the three-stage pipe
  localparam int RANDOM_ITEMS   = 190;   // per configuration phase
  localparam int REPORT_MAX     = 10;
  localparam int CW             = tba_pkg::COORD_W;
  localparam int AW             = tba_pkg::ADDR_W;
  localparam int CDW            = tba_pkg::CFG_DATA_W;

  // One input transfer: operation plus box corners
  typedef struct {
    tba_pkg::func_t func;
    logic [CW-1:0]  x1;
    logic [CW-1:0]  y1;
    logic [CW-1:0]  x2;
    logic [CW-1:0]  y2;
  } blit_item_t;

  // One expected result transfer
  typedef struct {
    logic [AW-1:0] src;
    logic [AW-1:0] dst;
    logic          last;
  } addr_pair_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wr_en  = 1'b0;
  logic [tba_pkg::CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CDW-1:0]                  cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tba_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // box_x1, box_y1, box_x2, box_y2, pad
  logic                            in_tuser   = 1'b0;  // func
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tba_pkg::OUT_TDATA_W-1:0] out_tdata;  // src_word_addr, dst_word_addr, pad
  logic                            out_tlast;  // last_of_box

  tiled_blit_address_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  blit_item_t items_to_send[$];
  addr_pair_t due_pairs[$];
  int         error_count  = 0;
  logic       in_taken     = 1'b0;
  logic       out_taken    = 1'b0;
  int         send_pause   = 0;
  int         recv_pause   = 0;
  blit_item_t next_item;

  // Predictor copy of registers and walk state
  logic [tba_pkg::STRIDE_W-1:0] pitch       = tba_pkg::STRIDE_W'(1280);
  logic [AW-1:0]                src_surface = '0;
  logic [AW-1:0]                dst_surface = '0;
  logic                         walking     = 1'b0;
  logic [CW-1:0]                org_x       = '0;
  logic [CW-1:0]                org_y       = '0;
  logic [tba_pkg::TILE_W-1:0]   tiles_x     = '0;
  logic [tba_pkg::TILE_W-1:0]   tiles_y     = '0;
  logic [tba_pkg::IDX_W-1:0]    cur_row     = '0;
  logic [tba_pkg::IDX_W-1:0]    cur_col     = '0;
  logic [tba_pkg::WORD_W-1:0]   cur_word    = '0;

  initial forever #10 clk = ~clk;

  // Mostly back-to-back, sometimes a random pause
  function automatic int draw_pause();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic blit_item_t start_item(input int x1, input int y1,
                                            input int x2, input int y2);
    blit_item_t it;
    it.func = tba_pkg::FUNC_START;
    it.x1   = CW'(x1);
    it.y1   = CW'(y1);
    it.x2   = CW'(x2);
    it.y2   = CW'(y2);
    return it;
  endfunction

  // Step transfers carry junk corners; the block must ignore them
  function automatic blit_item_t step_item();
    blit_item_t it;
    it      = start_item($urandom, $urandom, $urandom, $urandom);
    it.func = tba_pkg::FUNC_STEP;
    return it;
  endfunction

  // Start of a box spanning exactly ta x td tiles at a random place
  function automatic blit_item_t box_for_tiles(input int ta, input int td);
    int ox;
    int oy;
    ox = 32 * $urandom_range(0, 256 - ta);
    oy = 32 * $urandom_range(0, 256 - td);
    return start_item(ox + $urandom_range(0, 15), oy + $urandom_range(0, 15),
                      ox + 32 * (ta - 1) + $urandom_range(16, 31),
                      oy + 32 * (td - 1) + $urandom_range(16, 31));
  endfunction

  // Walk model: start loads a box, each step while walking yields one pair
  task automatic predict_addresses(input logic func_bit,
                                   input logic [tba_pkg::IN_TDATA_W-1:0] data);
    logic [CW-1:0]              x1;
    logic [CW-1:0]              y1;
    logic [CW-1:0]              x2;
    logic [CW-1:0]              y2;
    logic [tba_pkg::WORD_W-1:0] j;
    longint                     xx;
    longint                     yy;
    longint                     row_base;
    longint                     src_sum;
    longint                     dst_sum;
    addr_pair_t                 pair;
    x1 = data[CW-1:0];
    y1 = data[2*CW-1:CW];
    x2 = data[3*CW-1:2*CW];
    y2 = data[4*CW-1:3*CW];
    if (tba_pkg::func_t'(func_bit) == tba_pkg::FUNC_START) begin
      cur_row  = '0;
      cur_col  = '0;
      cur_word = '0;
      if (x2 <= x1 || y2 <= y1) begin
        walking = 1'b0;
      end else begin
        org_x   = x1 & ~CW'(31);
        org_y   = y1 & ~CW'(31);
        tiles_x = tba_pkg::TILE_W'((int'(x2) - int'(org_x) + 31) >> 5);
        tiles_y = tba_pkg::TILE_W'((int'(y2) - int'(org_y) + 31) >> 5);
        walking = 1'b1;
      end
    end else if (walking) begin
      // bit 8 of the word index flips bit 5 of the pixel index
      j    = cur_word ^ (tba_pkg::WORD_W'(cur_word[8]) << 5);
      xx   = longint'(j[1:0]) | (longint'(j[5:3]) << 2);
      yy   = longint'(j[2]) | (longint'(j[9:6]) << 1);
      row_base = (longint'(org_y) + 32 * longint'(cur_row)) * longint'(pitch);
      src_sum  = longint'(src_surface) + row_base + longint'(org_x)
                 + 32 * longint'(cur_col) + xx + yy * longint'(pitch);
      dst_sum  = longint'(dst_surface) + row_base + 32 * longint'(org_x)
                 + 1024 * longint'(cur_col) + longint'(cur_word);
      pair.src  = src_sum[AW-1:0];
      pair.dst  = dst_sum[AW-1:0];
      pair.last = (cur_word == tba_pkg::WORD_W'(1023))
                  && (int'(cur_col) + 1 >= int'(tiles_x))
                  && (int'(cur_row) + 1 >= int'(tiles_y));
      due_pairs.push_back(pair);
      // advance word, then tile in row, then tile row
      if (cur_word != tba_pkg::WORD_W'(1023)) begin
        cur_word = cur_word + tba_pkg::WORD_W'(1);
      end else begin
        cur_word = '0;
        if (int'(cur_col) + 1 < int'(tiles_x)) begin
          cur_col = cur_col + tba_pkg::IDX_W'(1);
        end else begin
          cur_col = '0;
          if (int'(cur_row) + 1 < int'(tiles_y)) begin
            cur_row = cur_row + tba_pkg::IDX_W'(1);
          end else begin
            cur_row = '0;
            walking = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Input driver: holds a transfer until taken, then pauses or sends the next
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (send_pause > 0) begin
        send_pause--;
        in_tvalid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        next_item  = items_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_item.func;
        in_tdata  <= {4'b0, next_item.y2, next_item.x2, next_item.y1, next_item.x1};
        send_pause = draw_pause();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, one draw per result transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken)
        recv_pause = draw_pause();
      if (recv_pause > 0) begin
        recv_pause--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Predict on every accepted input transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      predict_addresses(in_tuser, in_tdata);
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    addr_pair_t    want;
    logic [AW-1:0] got_src;
    logic [AW-1:0] got_dst;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got_src = out_tdata[AW-1:0];
      got_dst = out_tdata[2*AW-1:AW];
      if (due_pairs.size() == 0) begin
        flag_error($sformatf("unexpected result src=%h dst=%h last=%b",
                             got_src, got_dst, out_tlast));
      end else begin
        want = due_pairs.pop_front();
        if (got_src !== want.src || got_dst !== want.dst || out_tlast !== want.last)
          flag_error($sformatf("expected src=%h dst=%h last=%b, got src=%h dst=%h last=%b",
                               want.src, want.dst, want.last, got_src, got_dst, out_tlast));
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Register write, mirrored into the predictor
  task automatic write_reg(input tba_pkg::cfg_reg_t idx, input logic [CDW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      tba_pkg::CFG_STRIDE:   pitch       = value[tba_pkg::STRIDE_W-1:0];
      tba_pkg::CFG_SRC_BASE: src_surface = value[AW-1:0];
      tba_pkg::CFG_DST_BASE: dst_surface = value[AW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until all items are sent and all results are in, then let the pipe empty
  task automatic wait_drained();
    do
      @(posedge clk);
    while (items_to_send.size() != 0 || in_tvalid || due_pairs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random phase: small boxes abandoned part way, plus some noise
  task automatic queue_random_phase();
    int count;
    int pick;
    int n_steps;
    blit_item_t it;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        it      = step_item();
        it.func = tba_pkg::func_t'($urandom_range(0, 1));
        items_to_send.push_back(it);
        count++;
      end else begin
        if (pick < 4)
          it = start_item($urandom, $urandom, $urandom, $urandom);
        else
          it = box_for_tiles($urandom_range(1, 3), $urandom_range(1, 3));
        items_to_send.push_back(it);
        n_steps = $urandom_range(0, 50);
        if (n_steps > RANDOM_ITEMS - count - 1)
          n_steps = RANDOM_ITEMS - count - 1;
        repeat (n_steps) items_to_send.push_back(step_item());
        count += 1 + n_steps;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under reset register values
    items_to_send.push_back(step_item());                          // step with no box
    items_to_send.push_back(start_item(100, 10, 100, 60));         // zero width
    items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(300, 10, 200, 60));         // right edge left of left
    items_to_send.push_back(start_item(40, 50, 90, 50));           // zero height
    items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(0, 0, 8191, 8191));         // full coordinate span
    repeat (3) items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(8191, 8191, 8191, 8191));   // abandons, empty
    items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(31, 40, 33, 70));           // straddles tile edges
    repeat (3) items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(8160, 8160, 8191, 8191));   // top corner tile
    repeat (2) items_to_send.push_back(step_item());
    items_to_send.push_back(start_item(1000, 20, 1001, 21));       // single pixel
    items_to_send.push_back(step_item());
    wait_drained();

    // Register settings, extremes first
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_reg(tba_pkg::CFG_STRIDE, CDW'(32));
          write_reg(tba_pkg::CFG_SRC_BASE, CDW'(0));
          write_reg(tba_pkg::CFG_DST_BASE, CDW'(0));
        end
        2: begin
          write_reg(tba_pkg::CFG_STRIDE, CDW'(8192));
          write_reg(tba_pkg::CFG_SRC_BASE, {CDW{1'b1}});
          write_reg(tba_pkg::CFG_DST_BASE, {CDW{1'b1}});
        end
        3: begin
          write_reg(tba_pkg::CFG_STRIDE, CDW'({tba_pkg::STRIDE_W{1'b1}}));
          write_reg(tba_pkg::CFG_SRC_BASE, CDW'($urandom_range(0, (1 << AW) - 1)));
          write_reg(tba_pkg::CFG_DST_BASE, CDW'($urandom_range(0, (1 << AW) - 1)));
        end
        4: begin
          write_reg(tba_pkg::CFG_STRIDE, CDW'(0));
          write_reg(tba_pkg::CFG_SRC_BASE, CDW'($urandom_range(0, (1 << AW) - 1)));
          write_reg(tba_pkg::CFG_DST_BASE, CDW'(0));
        end
        default: begin
          write_reg(tba_pkg::CFG_STRIDE, CDW'($urandom_range(32, 8192)));
          write_reg(tba_pkg::CFG_SRC_BASE, CDW'($urandom_range(0, (1 << AW) - 1)));
          write_reg(tba_pkg::CFG_DST_BASE, CDW'($urandom_range(0, (1 << AW) - 1)));
        end
      endcase
      queue_random_phase();
      wait_drained();
    end

    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
